// ----- rtl/ntcplc_pkg.sv -----
`timescale 1ns / 1ps

package ntcplc_pkg;

   localparam int TABLE_POINTS = 33;
   localparam int IDX_W        = $clog2(TABLE_POINTS);
   localparam int CODE_W       = 12;
   localparam int TEMP_W       = 19;
   localparam int VALUE_W      = 32;
   // Largest span or pair difference in either column is below 2**15.
   localparam int MAG_W        = 15;
   // Offset stays below its span, so the product stays below 2**23.
   localparam int PROD_W       = 23;
   localparam int CNT_W        = $clog2(PROD_W);

   typedef logic [IDX_W-1:0] idx_type;

   localparam logic [CODE_W-1:0] CODE_TABLE [TABLE_POINTS] = '{
      12'hF8D, 12'hF6A, 12'hF29, 12'hEE4, 12'hE9D, 12'hE3F, 12'hDBF, 12'hD33,
      12'hC97, 12'hBF5, 12'hB3A, 12'hA42, 12'h7F1, 12'h734, 12'h66B, 12'h5A3,
      12'h4EE, 12'h446, 12'h43A, 12'h430, 12'h3C3, 12'h3BD, 12'h33B, 12'h2BB,
      12'h259, 12'h206, 12'h1CE, 12'h191, 12'h160, 12'h12E, 12'h0F9, 12'h0D7,
      12'h09F
   };

   localparam logic signed [TEMP_W-1:0] MDEG_TABLE [TABLE_POINTS] = '{
      -19'sd26428, -19'sd21922, -19'sd15958, -19'sd11060, -19'sd6890,
      -19'sd2264,   19'sd2961,   19'sd7818,   19'sd12525,  19'sd16945,
       19'sd21623,  19'sd27431,  19'sd40631,  19'sd44960,  19'sd49757,
       19'sd54854,  19'sd59898,  19'sd65076,  19'sd65779,  19'sd65856,
       19'sd69654,  19'sd69873,  19'sd74910,  19'sd80691,  19'sd85844,
       19'sd90915,  19'sd94873,  19'sd99720,  19'sd104216, 19'sd109531,
       19'sd116445, 19'sd121600, 19'sd131839
   };

   localparam logic MODE_CODE_TO_TEMP = 1'b0;
   localparam logic MODE_TEMP_TO_CODE = 1'b1;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_CHECK  = 8'b0000_0010,
      ST_SEARCH = 8'b0000_0100,
      ST_SEG    = 8'b0000_1000,
      ST_MUL    = 8'b0001_0000,
      ST_DIV    = 8'b0010_0000,
      ST_ADJ    = 8'b0100_0000,
      ST_FIN    = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic load;
      logic check;
      logic step;
      logic seg;
      logic mul;
      logic div_step;
      logic adj;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic sat;
      logic search_done;
      logic exact;
   } sts_type;

   // Search key of an entry: code in code-to-temp mode, temperature otherwise.
   function automatic logic signed [VALUE_W-1:0] key_at(input logic mode, input idx_type idx);
      logic signed [VALUE_W-1:0] k;
      if (mode == MODE_TEMP_TO_CODE) begin
         k = {{(VALUE_W-TEMP_W){MDEG_TABLE[idx][TEMP_W-1]}}, MDEG_TABLE[idx]};
      end else begin
         k = {{(VALUE_W-CODE_W){1'b0}}, CODE_TABLE[idx]};
      end
      return k;
   endfunction

   // Paired value of an entry, the opposite column of key_at.
   function automatic logic signed [TEMP_W-1:0] pair_at(input logic mode, input idx_type idx);
      logic signed [TEMP_W-1:0] p;
      if (mode == MODE_TEMP_TO_CODE) begin
         p = {{(TEMP_W-CODE_W){1'b0}}, CODE_TABLE[idx]};
      end else begin
         p = MDEG_TABLE[idx];
      end
      return p;
   endfunction

endpackage

// ----- rtl/ntc_piecewise_linear_converter_core.sv -----
`timescale 1ns / 1ps
// A transaction that saturates at a table end goes from the check step to
// the finish step; one on an exact table point goes to the finish step after
// the search and segment steps; otherwise it interpolates (5-step binary
// search, multiply, 23-step divider). A stalled earlier result holds the finish step.
// Throughput: one transaction at a time; the next is taken once the result is
// in the output register. Synchronous active-high reset clears control only.
module ntc_piecewise_linear_converter_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_mode,
   input  logic signed [ntcplc_pkg::VALUE_W-1:0]  req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [ntcplc_pkg::TEMP_W-1:0]   rsp_converted
);

   ntcplc_pkg::cmd_type cmd;
   ntcplc_pkg::sts_type sts;

   ntcplc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   ntcplc_dpath u_dpath (
      .clock         (clock),
      .cmd           (cmd),
      .sts           (sts),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .rsp_converted (rsp_converted)
   );

endmodule

// ----- rtl/ntcplc_dpath.sv -----
`timescale 1ns / 1ps

module ntcplc_dpath (
   input  logic                                        clock,
   input  ntcplc_pkg::cmd_type                         cmd,
   output ntcplc_pkg::sts_type                         sts,
   input  logic                                        req_mode,
   input  logic signed [ntcplc_pkg::VALUE_W-1:0]       req_value,
   output logic signed [ntcplc_pkg::TEMP_W-1:0]        rsp_converted
);

   localparam int IDX_W   = ntcplc_pkg::IDX_W;
   localparam int VALUE_W = ntcplc_pkg::VALUE_W;
   localparam int TEMP_W  = ntcplc_pkg::TEMP_W;
   localparam int MAG_W   = ntcplc_pkg::MAG_W;
   localparam int PROD_W  = ntcplc_pkg::PROD_W;

   logic                        mode_ff,  mode_in;
   logic signed [VALUE_W-1:0]   value_ff, value_in;
   ntcplc_pkg::idx_type         lo_ff,    lo_in;
   ntcplc_pkg::idx_type         hi_ff,    hi_in;
   logic signed [TEMP_W-1:0]    res_ff,   res_in;
   logic                        neg_ff,   neg_in;
   logic [MAG_W-1:0]            dmag_ff,  dmag_in;
   logic [MAG_W-1:0]            omag_ff,  omag_in;
   logic [MAG_W-1:0]            smag_ff,  smag_in;
   logic [MAG_W-1:0]            rem_ff,   rem_in;
   logic [PROD_W-1:0]           quo_ff,   quo_in;
   logic signed [TEMP_W-1:0]    out_ff,   out_in;

   logic signed [VALUE_W-1:0]   key_first, key_last, key_mid, key_k, key_km1;
   logic signed [TEMP_W-1:0]    pair_k, pair_km1, sat_pair;
   logic                        at_first, at_last, pred;
   logic [IDX_W:0]              mid_sum;
   ntcplc_pkg::idx_type         mid, km1;
   logic signed [VALUE_W-1:0]   off_full, span_full;
   logic [VALUE_W-1:0]          off_abs, span_abs;
   logic signed [TEMP_W:0]      delta_full;
   logic [TEMP_W:0]             delta_abs;
   logic [2*MAG_W-1:0]          prod;
   logic [MAG_W:0]              shifted;
   logic [MAG_W+1:0]            trial;
   logic signed [TEMP_W-1:0]    quo_ext;

   always_comb begin
      key_first = ntcplc_pkg::key_at(mode_ff, '0);
      key_last  = ntcplc_pkg::key_at(mode_ff, IDX_W'(ntcplc_pkg::TABLE_POINTS - 1));
      if (mode_ff == ntcplc_pkg::MODE_TEMP_TO_CODE) begin
         at_first = (value_ff <= key_first);
         at_last  = (value_ff >= key_last);
      end else begin
         at_first = (value_ff >= key_first);
         at_last  = (value_ff <= key_last);
      end
      sat_pair = at_first ? ntcplc_pkg::pair_at(mode_ff, '0)
                          : ntcplc_pkg::pair_at(mode_ff,
                                                IDX_W'(ntcplc_pkg::TABLE_POINTS - 1));

      // Find the first entry at or past the value in table order.
      mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
      mid     = mid_sum[IDX_W:1];
      key_mid = ntcplc_pkg::key_at(mode_ff, mid);
      if (mode_ff == ntcplc_pkg::MODE_TEMP_TO_CODE) begin
         pred = (value_ff <= key_mid);
      end else begin
         pred = (value_ff >= key_mid);
      end

      km1      = lo_ff - 1'b1;
      key_k    = ntcplc_pkg::key_at(mode_ff, lo_ff);
      key_km1  = ntcplc_pkg::key_at(mode_ff, km1);
      pair_k   = ntcplc_pkg::pair_at(mode_ff, lo_ff);
      pair_km1 = ntcplc_pkg::pair_at(mode_ff, km1);

      off_full   = value_ff - key_k;
      span_full  = key_km1 - key_k;
      delta_full = (TEMP_W+1)'(pair_km1) - (TEMP_W+1)'(pair_k);
      off_abs    = off_full[VALUE_W-1]  ? (~off_full + 1'b1)  : off_full;
      span_abs   = span_full[VALUE_W-1] ? (~span_full + 1'b1) : span_full;
      delta_abs  = delta_full[TEMP_W]   ? (~delta_full + 1'b1) : delta_full;

      prod    = dmag_ff * omag_ff;
      shifted = {rem_ff, quo_ff[PROD_W-1]};
      trial   = {1'b0, shifted} - {2'b00, smag_ff};
      quo_ext = {{(TEMP_W-MAG_W){1'b0}}, quo_ff[MAG_W-1:0]};

      sts.sat         = at_first || at_last;
      sts.search_done = (lo_ff == hi_ff);
      sts.exact       = (value_ff == key_k);
   end

   always_comb begin
      mode_in  = mode_ff;
      value_in = value_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      res_in   = res_ff;
      neg_in   = neg_ff;
      dmag_in  = dmag_ff;
      omag_in  = omag_ff;
      smag_in  = smag_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      out_in   = out_ff;

      if (cmd.load) begin
         mode_in  = req_mode;
         value_in = req_value;
         lo_in    = IDX_W'(1);
         hi_in    = IDX_W'(ntcplc_pkg::TABLE_POINTS - 1);
      end
      if (cmd.check) begin
         res_in = sat_pair;
      end
      if (cmd.step) begin
         if (pred) begin
            hi_in = mid;
         end else begin
            lo_in = mid + 1'b1;
         end
      end
      if (cmd.seg) begin
         res_in  = pair_k;
         neg_in  = off_full[VALUE_W-1] ^ span_full[VALUE_W-1] ^ delta_full[TEMP_W];
         dmag_in = delta_abs[MAG_W-1:0];
         omag_in = off_abs[MAG_W-1:0];
         smag_in = span_abs[MAG_W-1:0];
      end
      if (cmd.mul) begin
         quo_in = prod[PROD_W-1:0];
         rem_in = '0;
      end
      // Restoring division, one quotient bit per step.
      if (cmd.div_step) begin
         if (!trial[MAG_W+1]) begin
            rem_in = trial[MAG_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[MAG_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b0};
         end
      end
      if (cmd.adj) begin
         res_in = neg_ff ? (res_ff - quo_ext) : (res_ff + quo_ext);
      end
      if (cmd.out_load) begin
         out_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      value_ff <= value_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      res_ff   <= res_in;
      neg_ff   <= neg_in;
      dmag_ff  <= dmag_in;
      omag_ff  <= omag_in;
      smag_ff  <= smag_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      out_ff   <= out_in;
   end

   assign rsp_converted = out_ff;

endmodule

// ----- rtl/ntcplc_ctrl.sv -----
`timescale 1ns / 1ps

module ntcplc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ntcplc_pkg::cmd_type  cmd,
   input  ntcplc_pkg::sts_type  sts
);

   localparam int CNT_W  = ntcplc_pkg::CNT_W;
   localparam int PROD_W = ntcplc_pkg::PROD_W;

   ntcplc_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff,   cnt_in;
   logic                  valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;

      unique case (state_ff)
         ntcplc_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ntcplc_pkg::ST_CHECK;
            end
         end
         ntcplc_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sts.sat ? ntcplc_pkg::ST_FIN : ntcplc_pkg::ST_SEARCH;
         end
         ntcplc_pkg::ST_SEARCH: begin
            if (sts.search_done) begin
               state_in = ntcplc_pkg::ST_SEG;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ntcplc_pkg::ST_SEG: begin
            cmd.seg  = 1'b1;
            state_in = sts.exact ? ntcplc_pkg::ST_FIN : ntcplc_pkg::ST_MUL;
         end
         ntcplc_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            cnt_in   = '0;
            state_in = ntcplc_pkg::ST_DIV;
         end
         ntcplc_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(PROD_W - 1)) begin
               state_in = ntcplc_pkg::ST_ADJ;
            end
         end
         ntcplc_pkg::ST_ADJ: begin
            cmd.adj  = 1'b1;
            state_in = ntcplc_pkg::ST_FIN;
         end
         ntcplc_pkg::ST_FIN: begin
            // Hold the finished result until the output register frees up.
            if (!valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ntcplc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ntcplc_pkg::ST_IDLE;
         end
      endcase

      valid_in = cmd.out_load || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ntcplc_pkg::ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign req_stall = (state_ff != ntcplc_pkg::ST_IDLE);
   assign rsp_valid = valid_ff;

`ifndef NO_ASSERTIONS
   a_cmd_onehot0: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

   a_valid_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff) |-> $past(state_ff == ntcplc_pkg::ST_FIN))
      else $error("result raised outside the finish step");

   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ntcplc_pkg::ST_FIN) && valid_ff && rsp_stall
      |=> (state_ff == ntcplc_pkg::ST_FIN))
      else $error("finished result dropped while output blocked");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ntcplc_pkg::ST_DIV) |-> (cnt_ff < CNT_W'(PROD_W)))
      else $error("division step count overran");
`endif

endmodule

// ----- tb/tb_ntc_piecewise_linear_converter_core.sv -----
`timescale 1ns / 1ps

module tb_ntc_piecewise_linear_converter_core;

   localparam int  TABLE_POINTS = ntcplc_pkg::TABLE_POINTS;
   localparam int  VALUE_W      = ntcplc_pkg::VALUE_W;
   localparam int  TEMP_W       = ntcplc_pkg::TEMP_W;
   localparam int  RANDOM_ITEMS = 1500;
   localparam int  IDLE_PCT     = 32;
   localparam int  HOLD_CYCLES  = 300;
   localparam int  TAIL_CYCLES  = 40;
   localparam int  REPORT_LIMIT = 10;

   localparam int CURVE_CODE [TABLE_POINTS] = '{
      'hF8D, 'hF6A, 'hF29, 'hEE4, 'hE9D, 'hE3F, 'hDBF, 'hD33, 'hC97, 'hBF5, 'hB3A,
      'hA42, 'h7F1, 'h734, 'h66B, 'h5A3, 'h4EE, 'h446, 'h43A, 'h430, 'h3C3, 'h3BD,
      'h33B, 'h2BB, 'h259, 'h206, 'h1CE, 'h191, 'h160, 'h12E, 'h0F9, 'h0D7, 'h09F
   };

   localparam int CURVE_MDEG [TABLE_POINTS] = '{
      -26428, -21922, -15958, -11060, -6890, -2264, 2961, 7818, 12525, 16945,
      21623, 27431, 40631, 44960, 49757, 54854, 59898, 65076, 65779, 65856,
      69654, 69873, 74910, 80691, 85844, 90915, 94873, 99720, 104216, 109531,
      116445, 121600, 131839
   };

   typedef struct {
      logic                       mode;
      logic signed [VALUE_W-1:0]  value;
      bit                         typed;
      logic signed [TEMP_W-1:0]   want;
   } vector_t;

   typedef struct {
      logic                       mode;
      logic signed [VALUE_W-1:0]  value;
      logic signed [TEMP_W-1:0]   converted;
   } conversion_t;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_mode = ntcplc_pkg::MODE_CODE_TO_TEMP;
   logic signed [VALUE_W-1:0]  req_value = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [TEMP_W-1:0]   rsp_converted;

   vector_t     directed_rows [$];
   conversion_t pending_conversions [$];
   int          failure_count = 0;
   int          hold_requests = 0;
   bit          no_idle = 1'b0;

   ntc_piecewise_linear_converter_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_converted (rsp_converted)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // Temperature-to-code runs on negated temperatures so both directions search a
   // descending key column; truncating division is symmetric under the double negation.
   function automatic logic signed [TEMP_W-1:0] expected_conversion(
      input logic m, input logic signed [VALUE_W-1:0] v);
      longint key [TABLE_POINTS];
      longint pair [TABLE_POINTS];
      longint x;
      longint r;
      bit     found;
      for (int k = 0; k < TABLE_POINTS; k++) begin
         key[k]  = (m == ntcplc_pkg::MODE_TEMP_TO_CODE) ? -longint'(CURVE_MDEG[k])
                                                        : longint'(CURVE_CODE[k]);
         pair[k] = (m == ntcplc_pkg::MODE_TEMP_TO_CODE) ? longint'(CURVE_CODE[k])
                                                        : longint'(CURVE_MDEG[k]);
      end
      x = (m == ntcplc_pkg::MODE_TEMP_TO_CODE) ? -longint'(v) : longint'(v);
      found = 1'b0;
      r = pair[TABLE_POINTS-1];
      if (x >= key[0]) begin
         r = pair[0];
      end else if (x > key[TABLE_POINTS-1]) begin
         for (int k = 1; k < TABLE_POINTS && !found; k++) begin
            if (x == key[k]) begin
               r = pair[k];
               found = 1'b1;
            end else if (x > key[k]) begin
               r = pair[k] + ((pair[k-1] - pair[k]) * (x - key[k])) / (key[k-1] - key[k]);
               found = 1'b1;
            end
         end
      end
      return r[TEMP_W-1:0];
   endfunction

   function automatic logic signed [VALUE_W-1:0] random_value(input logic m);
      int sel;
      int k;
      int base;
      sel  = $urandom_range(0, 99);
      k    = $urandom_range(0, TABLE_POINTS-1);
      base = (m == ntcplc_pkg::MODE_TEMP_TO_CODE) ? CURVE_MDEG[k] : CURVE_CODE[k];
      if (sel < 10) begin
         return $urandom();
      end else if (sel < 40) begin
         // land on or right next to a table point
         return base + int'($urandom_range(0, 8)) - 4;
      end else if (m == ntcplc_pkg::MODE_TEMP_TO_CODE) begin
         return int'($urandom_range(0, 164000)) - 30000;
      end else begin
         return int'($urandom_range(0, 4095));
      end
   endfunction

   task automatic add_row(input logic m, input logic signed [VALUE_W-1:0] v,
                          input bit typed, input int want);
      vector_t row;
      row.mode  = m;
      row.value = v;
      row.typed = typed;
      row.want  = TEMP_W'(want);
      directed_rows.push_back(row);
   endtask

   task automatic log_failure(input string what, input conversion_t c);
      failure_count++;
      if (failure_count <= REPORT_LIMIT) begin
         $display("%s: mode %0d value %0d expected %0d actual %0d", what, c.mode,
                  c.value, c.converted, rsp_converted);
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_conversion(input logic m, input logic signed [VALUE_W-1:0] v,
                                  input bit typed, input logic signed [TEMP_W-1:0] want);
      conversion_t c;
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= m;
      req_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      c.mode      = m;
      c.value     = v;
      c.converted = typed ? want : expected_conversion(m, v);
      pending_conversions.push_back(c);
      @(negedge clock);
   endtask

   initial begin : receiver
      int hold_done;
      hold_done = 0;
      forever begin
         @(negedge clock);
         if (hold_done < hold_requests) begin
            hold_done++;
            rsp_stall <= 1'b1;
            for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clock);
         end
         rsp_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      conversion_t head;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_conversions.size() == 0) begin
            head = '{mode: 1'b0, value: '0, converted: '0};
            log_failure("unexpected result", head);
         end else begin
            head = pending_conversions.pop_front();
            if (rsp_converted !== head.converted) log_failure("converted mismatch", head);
         end
      end
   end

   initial begin : stimulus
      logic m;
      add_row(ntcplc_pkg::MODE_CODE_TO_TEMP, 32'sh7FFFFFFF, 1'b1, -26428);
      add_row(ntcplc_pkg::MODE_CODE_TO_TEMP, 32'sh80000000, 1'b1, 131839);
      add_row(ntcplc_pkg::MODE_CODE_TO_TEMP, 4095,          1'b1, -26428);
      add_row(ntcplc_pkg::MODE_CODE_TO_TEMP, 0,             1'b1, 131839);
      add_row(ntcplc_pkg::MODE_CODE_TO_TEMP, 'hF8D,         1'b1, -26428);
      add_row(ntcplc_pkg::MODE_CODE_TO_TEMP, 'h09F,         1'b1, 131839);
      add_row(ntcplc_pkg::MODE_CODE_TO_TEMP, 'hF6A,         1'b1, -21922);
      add_row(ntcplc_pkg::MODE_CODE_TO_TEMP, 'h43A,         1'b1, 65779);
      add_row(ntcplc_pkg::MODE_CODE_TO_TEMP, -1,            1'b1, 131839);
      add_row(ntcplc_pkg::MODE_CODE_TO_TEMP, 'hF8C,         1'b0, 0);
      add_row(ntcplc_pkg::MODE_CODE_TO_TEMP, 'h0A0,         1'b0, 0);
      add_row(ntcplc_pkg::MODE_CODE_TO_TEMP, 'h800,         1'b0, 0);
      add_row(ntcplc_pkg::MODE_CODE_TO_TEMP, 'h3C0,         1'b0, 0);
      add_row(ntcplc_pkg::MODE_TEMP_TO_CODE, 32'sh80000000, 1'b1, 'hF8D);
      add_row(ntcplc_pkg::MODE_TEMP_TO_CODE, 32'sh7FFFFFFF, 1'b1, 'h09F);
      add_row(ntcplc_pkg::MODE_TEMP_TO_CODE, -26428,        1'b1, 'hF8D);
      add_row(ntcplc_pkg::MODE_TEMP_TO_CODE, 131839,        1'b1, 'h09F);
      add_row(ntcplc_pkg::MODE_TEMP_TO_CODE, -21922,        1'b1, 'hF6A);
      add_row(ntcplc_pkg::MODE_TEMP_TO_CODE, 65856,         1'b1, 'h430);
      add_row(ntcplc_pkg::MODE_TEMP_TO_CODE, -26427,        1'b0, 0);
      add_row(ntcplc_pkg::MODE_TEMP_TO_CODE, 131838,        1'b0, 0);
      add_row(ntcplc_pkg::MODE_TEMP_TO_CODE, 0,             1'b0, 0);
      add_row(ntcplc_pkg::MODE_TEMP_TO_CODE, -1,            1'b0, 0);
      add_row(ntcplc_pkg::MODE_TEMP_TO_CODE, 50000,         1'b0, 0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_conversion(directed_rows[i].mode, directed_rows[i].value,
                         directed_rows[i].typed, directed_rows[i].want);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // run a stretch with no idling on either side, and stall the output inside it
         if (n == 400) no_idle = 1'b1;
         if (n == 450) hold_requests++;
         if (n == 700) no_idle = 1'b0;
         m = 1'($urandom_range(0, 1));
         send_conversion(m, random_value(m), 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (pending_conversions.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failure_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
